[rtl/slecm_pkg.sv]
// ----------------------------------------------------------------------------
// slecm_pkg - shared types and constants
// Event codes, character constants and line sizing for the serial line editor
// command matcher.
// ----------------------------------------------------------------------------
package slecm_pkg;

    localparam int LINE_CAP   = 256;
    localparam int LEN_W      = $clog2(LINE_CAP);
    localparam int HEAD_DEPTH = 7;

    typedef logic [7:0]                     char_t;
    typedef logic [LEN_W-1:0]               len_t;
    typedef logic [HEAD_DEPTH-1:0][7:0]     head_t;

    typedef enum logic [2:0] {
        EV_ECHO     = 3'd0,
        EV_ERASE    = 3'd1,
        EV_LED_ON   = 3'd2,
        EV_LED_OFF  = 3'd3,
        EV_STATUS   = 3'd4,
        EV_HELP     = 3'd5,
        EV_UNKNOWN  = 3'd6,
        EV_OVERFLOW = 3'd7
    } event_t;

    localparam char_t CH_BS    = 8'h08;
    localparam char_t CH_DEL   = 8'h7F;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_FIRST = 8'h20;
    localparam char_t CH_LAST  = 8'h7E;

    // Command words, first character in the lowest byte
    localparam logic [47:0] CMD_LED_ON  = {"N", "O", "_", "D", "E", "L"};
    localparam logic [55:0] CMD_LED_OFF = {"F", "F", "O", "_", "D", "E", "L"};
    localparam logic [47:0] CMD_STATUS  = {"S", "U", "T", "A", "T", "S"};
    localparam logic [31:0] CMD_HELP    = {"P", "L", "E", "H"};

    typedef struct packed {
        event_t      ev;
        logic [7:0]  echo_char;
        logic [7:0]  line_length;
        logic        blink_enabled;
    } result_t;

endpackage

[rtl/serial_line_editor_command_matcher_core.sv]
// ----------------------------------------------------------------------------
// serial_line_editor_command_matcher_core - serial line editor top level
// Each accepted byte is held in the input register; its result is then registered on m_*.
// Throughput: one byte per cycle while m_* is not stalled; the line state updates with each byte.
// Backpressure on m_* stalls the input register, also for bytes with no result.
// Reset: synchronous, active low; clears the line and sets blinking on.
// ----------------------------------------------------------------------------
module serial_line_editor_command_matcher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [2:0] event_res, [10:3] echo_char,
                                   // [18:11] line_length, [19] blink_enabled
);
    import slecm_pkg::*;

    logic    in_valid_reg;
    char_t   in_byte_reg;
    logic    m_valid_reg;
    result_t m_data_reg;

    logic    out_ready;
    logic    fire;
    logic    res_valid;
    result_t res;

    assign out_ready = !m_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    slecm_editor u_editor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg.blink_enabled, m_data_reg.line_length,
                       m_data_reg.echo_char, m_data_reg.ev};

`ifndef NO_ASSERTIONS
    a_echo_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_data_reg.ev != EV_ECHO)) |-> (m_data_reg.echo_char == 8'd0))
        else $error("echo_char set on a non-echo item");

    a_len_cmd_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_data_reg.ev == EV_ECHO || m_data_reg.ev == EV_ERASE
                      || m_data_reg.ev == EV_OVERFLOW))
        |-> (m_data_reg.line_length == 8'd0))
        else $error("line_length set on a non-command item");

    a_led_on_blink: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_data_reg.ev == EV_LED_ON)) |-> m_data_reg.blink_enabled)
        else $error("LED_ON did not enable blinking");

    a_led_off_blink: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_data_reg.ev == EV_LED_OFF)) |-> !m_data_reg.blink_enabled)
        else $error("LED_OFF did not disable blinking");
`endif

endmodule

[rtl/slecm_match.sv]
// ----------------------------------------------------------------------------
// slecm_match - command matcher
// Compares the stored line head and length against the known command words.
// ----------------------------------------------------------------------------
module slecm_match (
    input  slecm_pkg::head_t  head,
    input  slecm_pkg::len_t   len,
    output slecm_pkg::event_t cmd_ev
);
    import slecm_pkg::*;

    logic hit_led_on;
    logic hit_led_off;
    logic hit_status;
    logic hit_help;

    assign hit_led_on  = (len == LEN_W'(6)) && (head[5:0] == CMD_LED_ON);
    assign hit_led_off = (len == LEN_W'(7)) && (head[6:0] == CMD_LED_OFF);
    assign hit_status  = (len == LEN_W'(6)) && (head[5:0] == CMD_STATUS);
    assign hit_help    = (len == LEN_W'(4)) && (head[3:0] == CMD_HELP);

    always_comb begin
        if (hit_led_on) begin
            cmd_ev = EV_LED_ON;
        end else if (hit_led_off) begin
            cmd_ev = EV_LED_OFF;
        end else if (hit_status) begin
            cmd_ev = EV_STATUS;
        end else if (hit_help) begin
            cmd_ev = EV_HELP;
        end else begin
            cmd_ev = EV_UNKNOWN;
        end
    end

endmodule

[rtl/slecm_editor.sv]
// ----------------------------------------------------------------------------
// slecm_editor - line editor state
// Holds the line head, line length and blink flag, and turns one byte into
// at most one result per cycle.
// ----------------------------------------------------------------------------
module slecm_editor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  slecm_pkg::char_t    rx_byte,
    output logic                res_valid,
    output slecm_pkg::result_t  res
);
    import slecm_pkg::*;

    head_t  head_reg;
    head_t  head_next;
    len_t   len_reg;
    len_t   len_next;
    logic   blink_reg;
    logic   blink_next;

    len_t   len_minus;
    logic   is_enter;
    logic   is_erase;
    logic   is_print;
    logic   line_full;
    event_t cmd_ev;
    logic [LEN_W+7:0] len_wide;

    slecm_match u_match (
        .head   (head_reg),
        .len    (len_reg),
        .cmd_ev (cmd_ev)
    );

    assign is_enter  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_erase  = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    assign is_print  = (rx_byte >= CH_FIRST) && (rx_byte <= CH_LAST);
    assign line_full = (len_reg == LEN_W'(LINE_CAP - 1));
    assign len_minus = len_reg - LEN_W'(1);
    assign len_wide  = {8'd0, len_reg};

    always_comb begin
        head_next      = head_reg;
        len_next       = len_reg;
        blink_next     = blink_reg;
        res_valid      = 1'b0;
        res.ev         = EV_ECHO;
        res.echo_char  = 8'd0;
        res.line_length = 8'd0;
        if (fire) begin
            if (is_enter) begin
                if (len_reg != '0) begin
                    res_valid       = 1'b1;
                    res.ev          = cmd_ev;
                    res.line_length = len_wide[7:0];
                    if (cmd_ev == EV_LED_ON) begin
                        blink_next = 1'b1;
                    end else if (cmd_ev == EV_LED_OFF) begin
                        blink_next = 1'b0;
                    end
                    head_next = '0;
                    len_next  = '0;
                end
            end else if (is_erase) begin
                if (len_reg != '0) begin
                    res_valid = 1'b1;
                    res.ev    = EV_ERASE;
                    len_next  = len_minus;
                    for (int i = 0; i < HEAD_DEPTH; i++) begin
                        if (len_minus == LEN_W'(i)) begin
                            head_next[i] = 8'd0;
                        end
                    end
                end
            end else if (is_print) begin
                res_valid = 1'b1;
                if (!line_full) begin
                    res.ev        = EV_ECHO;
                    res.echo_char = rx_byte;
                    len_next      = len_reg + LEN_W'(1);
                    for (int i = 0; i < HEAD_DEPTH; i++) begin
                        if (len_reg == LEN_W'(i)) begin
                            head_next[i] = rx_byte;
                        end
                    end
                end else begin
                    // drop the byte and start over
                    res.ev    = EV_OVERFLOW;
                    head_next = '0;
                    len_next  = '0;
                end
            end
        end
        res.blink_enabled = blink_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            len_reg   <= '0;
            blink_reg <= 1'b1;
        end else begin
            head_reg  <= head_next;
            len_reg   <= len_next;
            blink_reg <= blink_next;
        end
    end

endmodule

[test/tb_serial_line_editor_command_matcher_core.sv]
// ----------------------------------------------------------------------------
// tb_serial_line_editor_command_matcher_core - line editor stream testbench
// Feeds received bytes into the editor and tracks its line state and blink
// flag alongside it. Every echo, erase, command and overflow item that comes
// out is checked field by field against the tracked state. Directed lines
// (commands, empty-line controls, full lines) come first, then random
// command, near-miss, edit and noise traffic with random idling on both
// sides, a long receiver hold-off and sender pauses between phases.
// ----------------------------------------------------------------------------
module tb_serial_line_editor_command_matcher_core;

    import slecm_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;

    typedef char_t text_t[$];

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // [2:0] event_res, [10:3] echo_char,
                                      // [18:11] line_length, [19] blink_enabled

    serial_line_editor_command_matcher_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Pending bytes and outstanding results
    char_t   rx_bytes_q[$];
    result_t line_events_q[$];

    // Tracked editor state
    char_t line_head[HEAD_DEPTH] = '{default: 8'h00};
    int    line_cnt = 0;
    bit    blink_on = 1'b1;

    int errors     = 0;
    int stim_count = 0;
    bit tx_idle    = 1'b1;
    bit rx_idle    = 1'b1;
    int hold_seq   = 0;

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch: %s got %0h expected %0h", what, got, want);
    endtask

    function automatic void clear_line();
        line_head = '{default: 8'h00};
        line_cnt  = 0;
    endfunction

    function automatic bit line_equals(string word);
        if (line_cnt != word.len() || word.len() > HEAD_DEPTH)
            return 1'b0;
        for (int i = 0; i < word.len(); i++)
            if (line_head[i] != char_t'(word[i]))
                return 1'b0;
        return 1'b1;
    endfunction

    // Apply one byte to the tracked line; returns 1 when it causes an item
    function automatic bit edit_line(input char_t c, output result_t ev_out);
        ev_out = '0;
        if (c == CH_CR || c == CH_LF) begin
            if (line_cnt == 0)
                return 1'b0;
            if (line_equals("LED_ON")) begin
                ev_out.ev = EV_LED_ON;
                blink_on  = 1'b1;
            end else if (line_equals("LED_OFF")) begin
                ev_out.ev = EV_LED_OFF;
                blink_on  = 1'b0;
            end else if (line_equals("STATUS")) begin
                ev_out.ev = EV_STATUS;
            end else if (line_equals("HELP")) begin
                ev_out.ev = EV_HELP;
            end else begin
                ev_out.ev = EV_UNKNOWN;
            end
            ev_out.line_length = line_cnt[7:0];
            clear_line();
        end else if (c == CH_BS || c == CH_DEL) begin
            if (line_cnt == 0)
                return 1'b0;
            line_cnt--;
            if (line_cnt < HEAD_DEPTH)
                line_head[line_cnt] = 8'h00;
            ev_out.ev = EV_ERASE;
        end else if (c >= CH_FIRST && c <= CH_LAST) begin
            if (line_cnt < LINE_CAP - 1) begin
                if (line_cnt < HEAD_DEPTH)
                    line_head[line_cnt] = c;
                line_cnt++;
                ev_out.ev        = EV_ECHO;
                ev_out.echo_char = c;
            end else begin
                clear_line();
                ev_out.ev = EV_OVERFLOW;
            end
        end else begin
            return 1'b0;
        end
        ev_out.blink_enabled = blink_on;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic char_t printable();
        return char_t'($urandom_range(CH_FIRST, CH_LAST));
    endfunction

    // Bytes the editor ignores: other control bytes and the upper half
    function automatic char_t noise_char();
        char_t c;
        case ($urandom_range(0, 2))
            0: c = char_t'($urandom_range(8'h80, 8'hFF));
            1: begin
                c = char_t'($urandom_range(8'h00, 8'h1F));
                if (c == CH_BS || c == CH_CR || c == CH_LF)
                    c = 8'h1B;
            end
            default: c = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        return c;
    endfunction

    function automatic text_t text_of(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(char_t'(s[i]));
        return t;
    endfunction

    function automatic string cmd_name(int idx);
        case (idx)
            0:       return "LED_ON";
            1:       return "LED_OFF";
            2:       return "STATUS";
            default: return "HELP";
        endcase
    endfunction

    task automatic push_char(char_t c);
        rx_bytes_q.push_back(c);
        if ((c >= CH_FIRST && c <= CH_LAST) || c == CH_BS || c == CH_DEL ||
            c == CH_CR || c == CH_LF)
            stim_count++;
    endtask

    task automatic push_erase();
        push_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
    endtask

    task automatic push_enter();
        push_char($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    // Messy text gets ignored bytes and corrected typos mixed in
    task automatic push_text(text_t t, bit messy);
        foreach (t[i]) begin
            if (messy && $urandom_range(0, 7) == 0)
                rx_bytes_q.push_back(noise_char());
            if (messy && $urandom_range(0, 9) == 0) begin
                push_char(printable());
                push_erase();
            end
            push_char(t[i]);
        end
    endtask

    task automatic push_line(text_t t, bit messy);
        push_text(t, messy);
        push_enter();
    endtask

    task automatic push_full_line();
        for (int i = 0; i < LINE_CAP - 1; i++)
            push_char(printable());
    endtask

    task automatic random_chunk();
        text_t t;
        int    sel;
        int    n;
        string letters;
        letters = "LEDO_NFSTAUHP";
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            push_line(text_of(cmd_name($urandom_range(0, 3))), $urandom_range(0, 1));
        end else if (sel < 50) begin
            // near misses of a command
            t = text_of(cmd_name($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: t[$urandom_range(0, t.size() - 1)] = printable();
                1: void'(t.pop_back());
                2: t.push_back(printable());
                default: t.push_front(printable());
            endcase
            push_line(t, 1'b0);
        end else if (sel < 65) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                t.push_back(printable());
            push_line(t, $urandom_range(0, 1));
        end else if (sel < 75) begin
            n = $urandom_range(1, 9);
            for (int i = 0; i < n; i++)
                t.push_back(char_t'(letters[$urandom_range(0, letters.len() - 1)]));
            push_line(t, 1'b0);
        end else if (sel < 85) begin
            // erase past the start of the line, then maybe retype
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                push_char(printable());
            n = $urandom_range(0, n + 2);
            for (int i = 0; i < n; i++)
                push_erase();
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                push_char(printable());
            if ($urandom_range(0, 3) != 0)
                push_enter();
        end else if (sel < 92) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                rx_bytes_q.push_back(noise_char());
        end else if (sel < 96) begin
            push_enter();
        end else begin
            push_erase();
        end
    endtask

    task automatic wait_drained();
        while (rx_bytes_q.size() != 0 || s_tvalid || line_events_q.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the oldest pending byte, predict on acceptance
    // ------------------------------------------------------------------------
    int tx_wait = 0;

    always @(posedge aclk) begin : drive
        result_t ev_next;
        logic    v;
        char_t   d;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            tx_wait = 0;
        end else begin
            v = s_tvalid;
            d = s_tdata;
            if (s_tvalid && s_tready) begin
                if (edit_line(s_tdata, ev_next))
                    line_events_q.push_back(ev_next);
                void'(rx_bytes_q.pop_front());
                v = 1'b0;
                tx_wait = tx_idle ? $urandom_range(0, 14) : 0;
            end
            if (!v) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (rx_bytes_q.size() != 0) begin
                    v = 1'b1;
                    d = rx_bytes_q[0];
                end
            end
            s_tvalid <= v;
            s_tdata  <= d;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: per-item stalls plus a long hold-off on request
    // ------------------------------------------------------------------------
    int rx_wait   = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                rx_wait = rx_idle ? $urandom_range(0, 14) : 0;
            else if (rx_wait > 0)
                rx_wait--;
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (rx_wait == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each item against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ev            = event_t'(m_tdata[2:0]);
            got.echo_char     = m_tdata[10:3];
            got.line_length   = m_tdata[18:11];
            got.blink_enabled = m_tdata[19];
            if (line_events_q.size() == 0) begin
                report_mismatch("unexpected item", int'(m_tdata), 0);
            end else begin
                want = line_events_q.pop_front();
                if (got.ev != want.ev)
                    report_mismatch("event_res", int'(got.ev), int'(want.ev));
                if (got.echo_char != want.echo_char)
                    report_mismatch("echo_char", got.echo_char, want.echo_char);
                if (got.line_length != want.line_length)
                    report_mismatch("line_length", got.line_length, want.line_length);
                if (got.blink_enabled != want.blink_enabled)
                    report_mismatch("blink_enabled", got.blink_enabled,
                                    want.blink_enabled);
                if (m_tdata[23:20] != 4'h0)
                    report_mismatch("tdata padding", m_tdata[23:20], 0);
            end
        end
    end

    // Watchdog: stop when neither side moves for too long
    int stuck_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout after %0d idle cycles", stuck_cycles);
            $display("tb_serial_line_editor_command_matcher_core failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        text_t t;
        int    target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty-line controls, ignored bytes, printable extremes
        push_char(CH_CR);
        push_char(CH_BS);
        push_char(CH_DEL);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CH_FIRST);
        push_char(CH_LAST);
        push_char(CH_DEL);
        push_char(CH_BS);
        push_char(CH_LF);
        push_char(CH_CR);
        push_line(text_of("LED_OFF"), 1'b0);
        push_line(text_of("LED_ON"), 1'b0);
        push_line(text_of("STATUS"), 1'b0);
        push_line(text_of("HELP"), 1'b0);
        push_line(text_of("X"), 1'b0);
        push_line(text_of("HELP_ME_NOW"), 1'b0);
        // eighth character is counted but not stored; erase it back to a match
        t = text_of("LED_OFFX");
        push_text(t, 1'b0);
        push_erase();
        push_enter();
        wait_drained();

        // Longest line, then overflow from a full line, with and without erase
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        push_full_line();
        push_enter();
        push_full_line();
        push_char(printable());
        push_line(text_of("LED_ON"), 1'b0);
        push_full_line();
        push_erase();
        push_char(printable());
        push_char(printable());
        push_enter();
        wait_drained();

        stim_count = 0;
        for (int p = 0; p < 6; p++) begin
            tx_idle = p[0];
            rx_idle = p[1];
            if (p == 4) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
                hold_seq++;
                push_full_line();
                push_char(printable());
            end
            target = stim_count + 65;
            while (stim_count < target)
                random_chunk();
            // hold the sender until the editor has caught up
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && line_events_q.size() == 0) begin
            $display("tb_serial_line_editor_command_matcher_core passed");
        end else begin
            $display("%0d mismatches, %0d items outstanding", errors,
                     line_events_q.size());
            $display("tb_serial_line_editor_command_matcher_core failed");
        end
        $finish;
    end

endmodule

[serial_line_editor_command_matcher_core.f]
rtl/slecm_pkg.sv
rtl/slecm_match.sv
rtl/slecm_editor.sv
rtl/serial_line_editor_command_matcher_core.sv
test/tb_serial_line_editor_command_matcher_core.sv
